@@ rtl/core/mer_pkg.sv @@
package mer_pkg;

  // Operation codes carried by the input item
  localparam logic OPER_START = 1'b0;
  localparam logic OPER_STEP  = 1'b1;

  // Fixed widths of the arithmetic
  localparam int COORD_W = 10;
  localparam int SQ_W    = 20;
  localparam int X_W     = 11;
  localparam int Y_W     = 12;
  localparam int SLOPE_W = 33;
  localparam int DEC_W   = 48;
  localparam int PROD_W  = 44;
  localparam int MUL_A_W = 20;
  localparam int MUL_B_W = 24;

  typedef struct packed {
    logic       operation;
    logic [9:0] center_x;
    logic [9:0] center_y;
    logic [9:0] radius_x;
    logic [9:0] radius_y;
    logic       fill_mode;
    logic [7:0] ink;
  } in_item_t;

  typedef struct packed {
    logic signed [11:0] pos_x;
    logic signed [11:0] pos_y;
    logic [10:0]        span_length;
    logic [7:0]         out_ink;
    logic               last;
  } out_item_t;

  // Datapath operations, one per controller step
  typedef enum logic [3:0] {
    DP_NONE,
    DP_START,
    DP_SQ_RY,
    DP_SQ_MIX,
    DP_INIT_DEC,
    DP_STEP_SLOPE,
    DP_STEP_DEC,
    DP_FINISH,
    DP_R2_TX,
    DP_R2_RYTX,
    DP_R2_YM,
    DP_R2_RXYM,
    DP_R2_RXRY,
    DP_R2_DONE
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic       capture;
    logic       emit_load;
    logic [1:0] emit_sel;
    logic       emit_final;
  } dp_cmd_t;

  typedef struct packed {
    logic active;
    logic region_two;
    logic enter_r2;
    logic fill;
    logic out_free;
  } dp_status_t;

endpackage

@@ rtl/core/midpoint_ellipse_rasterizer.sv @@
// A step's origin and result count are registered at its transfer; its results then
// enter the output register whenever it is free. A filled step runs accept, slope
// update, decision update and check; an outline step waits for its fourth pixel too.
// Leaving region one adds region-two setup (multiplier passes) and a second check. A start
// runs three multiplier passes from accept, decision setup and check; zero radius adds region two.
// Reset (rst_n low, synchronous) idles the block and drops any ellipse in progress.
module midpoint_ellipse_rasterizer #(
  parameter int COORD_MAX  = 1023,
  parameter int RADIUS_MAX = 1023
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mer_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output mer_pkg::out_item_t out_data
);

  // Command and status between the sequencer and the arithmetic
  mer_pkg::dp_cmd_t    cmd;
  mer_pkg::dp_status_t st;

  // Controller: sequences start setup, step update, region-two setup,
  // and hands results to the output register one transfer at a time.
  mer_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.operation),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // Datapath: latched ellipse parameters, exact slope terms, a decision term kept
  // exactly at four times scale, one shared 20x24 multiplier, output register.
  mer_dp #(
    .COORD_MAX  (COORD_MAX),
    .RADIUS_MAX (RADIUS_MAX)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ rtl/core/mer_dp.sv @@
module mer_dp #(
  parameter int COORD_MAX  = 1023,
  parameter int RADIUS_MAX = 1023
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mer_pkg::in_item_t   in_data,
  input  mer_pkg::dp_cmd_t    cmd,
  output mer_pkg::dp_status_t st,
  output logic                out_valid,
  input  logic                out_stall,
  output mer_pkg::out_item_t  out_data
);

  localparam logic [11:0] CMAX = 12'(COORD_MAX);
  localparam logic [11:0] RMAX = 12'(RADIUS_MAX);

  // control state
  logic active_r, active_nxt;
  logic region2_r, region2_nxt;
  logic out_valid_r, out_valid_nxt;

  // payload state
  logic [9:0]                       cx_r, cx_nxt;
  logic [9:0]                       cy_r, cy_nxt;
  logic [9:0]                       ry_r, ry_nxt;
  logic [mer_pkg::SQ_W-1:0]         rx_sq_r, rx_sq_nxt;
  logic [mer_pkg::SQ_W-1:0]         ry_sq_r, ry_sq_nxt;
  logic                             fill_r, fill_nxt;
  logic [7:0]                       ink_r, ink_nxt;
  logic [mer_pkg::X_W-1:0]          cur_x_r, cur_x_nxt;
  logic signed [mer_pkg::Y_W-1:0]   cur_y_r, cur_y_nxt;
  logic signed [mer_pkg::SLOPE_W-1:0] slope_x_r, slope_x_nxt;
  logic signed [mer_pkg::SLOPE_W-1:0] slope_y_r, slope_y_nxt;
  logic signed [mer_pkg::DEC_W-1:0] dec_r, dec_nxt;
  logic [mer_pkg::PROD_W-1:0]       prod_r, prod_nxt;
  logic [mer_pkg::X_W-1:0]          ex_r, ex_nxt;
  logic [mer_pkg::Y_W-1:0]          ey_r, ey_nxt;
  logic                             last_cap_r, last_cap_nxt;
  mer_pkg::out_item_t               out_data_r, out_data_nxt;

  logic [9:0]                       rx_in, ry_in;
  logic [mer_pkg::MUL_A_W-1:0]      mul_a;
  logic [mer_pkg::MUL_B_W-1:0]      mul_b;
  logic                             mul_en;
  logic [11:0]                      tx, ym, ym_abs;
  logic signed [mer_pkg::SLOPE_W-1:0] two_ry, two_rx;
  logic                             dec_neg, dec_pos;
  logic                             use_sx, use_sy;
  logic [mer_pkg::SQ_W-1:0]         c_sq;
  logic signed [mer_pkg::DEC_W-1:0] term;
  logic [mer_pkg::DEC_W-1:0]        prod_x4;
  logic                             out_free;
  logic                             xneg, yneg;

  assign rx_in = ({2'b00, in_data.radius_x} > RMAX) ? RMAX[9:0] : in_data.radius_x;
  assign ry_in = ({2'b00, in_data.radius_y} > RMAX) ? RMAX[9:0] : in_data.radius_y;

  assign tx     = {cur_x_r, 1'b1};
  assign ym     = cur_y_r - 12'sd1;
  assign ym_abs = ym[11] ? (12'd0 - ym) : ym;

  assign two_ry = $signed({12'b0, ry_sq_r, 1'b0});
  assign two_rx = $signed({12'b0, rx_sq_r, 1'b0});

  assign dec_neg = dec_r[mer_pkg::DEC_W-1];
  assign dec_pos = !dec_neg && (dec_r != '0);

  assign prod_x4 = {2'b00, prod_r, 2'b00};

  // Decision increment term: A - B + C, picked by region and branch
  assign use_sx = !(region2_r && dec_pos);
  assign use_sy = region2_r || !dec_neg;
  assign c_sq   = region2_r ? rx_sq_r : ry_sq_r;
  assign term   = (use_sx ? {{15{slope_x_r[32]}}, slope_x_r} : 48'sd0)
                - (use_sy ? {{15{slope_y_r[32]}}, slope_y_r} : 48'sd0)
                + $signed({28'b0, c_sq});

  assign out_free = !out_valid_r || !out_stall;

  // Shared multiplier operand select
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    unique case (cmd.op)
      mer_pkg::DP_START: begin
        mul_a = {10'b0, rx_in};
        mul_b = {14'b0, rx_in};
      end
      mer_pkg::DP_SQ_RY: begin
        mul_a = {10'b0, ry_r};
        mul_b = {14'b0, ry_r};
      end
      mer_pkg::DP_SQ_MIX: begin
        mul_a = rx_sq_r;
        mul_b = {14'b0, ry_r};
      end
      mer_pkg::DP_R2_TX: begin
        mul_a = {8'b0, tx};
        mul_b = {12'b0, tx};
      end
      mer_pkg::DP_R2_RYTX: begin
        mul_a = ry_sq_r;
        mul_b = prod_r[23:0];
      end
      mer_pkg::DP_R2_YM: begin
        mul_a = {8'b0, ym_abs};
        mul_b = {12'b0, ym_abs};
      end
      mer_pkg::DP_R2_RXYM: begin
        mul_a = rx_sq_r;
        mul_b = prod_r[23:0];
      end
      mer_pkg::DP_R2_RXRY: begin
        mul_a = rx_sq_r;
        mul_b = {4'b0, ry_sq_r};
      end
      default: mul_en = 1'b0;
    endcase
  end

  always_comb begin
    active_nxt  = active_r;
    region2_nxt = region2_r;
    cx_nxt      = cx_r;
    cy_nxt      = cy_r;
    ry_nxt      = ry_r;
    rx_sq_nxt   = rx_sq_r;
    ry_sq_nxt   = ry_sq_r;
    fill_nxt    = fill_r;
    ink_nxt     = ink_r;
    cur_x_nxt   = cur_x_r;
    cur_y_nxt   = cur_y_r;
    slope_x_nxt = slope_x_r;
    slope_y_nxt = slope_y_r;
    dec_nxt     = dec_r;
    prod_nxt    = mul_en ? ({24'b0, mul_a} * {20'b0, mul_b}) : prod_r;

    unique case (cmd.op)
      mer_pkg::DP_START: begin
        cx_nxt      = ({2'b00, in_data.center_x} > CMAX) ? CMAX[9:0] : in_data.center_x;
        cy_nxt      = ({2'b00, in_data.center_y} > CMAX) ? CMAX[9:0] : in_data.center_y;
        ry_nxt      = ry_in;
        fill_nxt    = in_data.fill_mode;
        ink_nxt     = in_data.ink;
        cur_x_nxt   = '0;
        cur_y_nxt   = $signed({2'b00, ry_in});
        slope_x_nxt = '0;
        region2_nxt = 1'b0;
        active_nxt  = 1'b1;
      end
      mer_pkg::DP_SQ_RY:  rx_sq_nxt = prod_r[mer_pkg::SQ_W-1:0];
      mer_pkg::DP_SQ_MIX: ry_sq_nxt = prod_r[mer_pkg::SQ_W-1:0];
      mer_pkg::DP_INIT_DEC: begin
        slope_y_nxt = $signed({1'b0, prod_r[30:0], 1'b0});
        dec_nxt     = $signed({26'b0, ry_sq_r, 2'b00}) - $signed(prod_x4)
                    + $signed({28'b0, rx_sq_r});
      end
      mer_pkg::DP_STEP_SLOPE: begin
        if (!region2_r) begin
          cur_x_nxt   = cur_x_r + 11'd1;
          slope_x_nxt = slope_x_r + two_ry;
          if (!dec_neg) begin
            cur_y_nxt   = cur_y_r - 12'sd1;
            slope_y_nxt = slope_y_r - two_rx;
          end
        end else begin
          cur_y_nxt   = cur_y_r - 12'sd1;
          slope_y_nxt = slope_y_r - two_rx;
          if (!dec_pos) begin
            cur_x_nxt   = cur_x_r + 11'd1;
            slope_x_nxt = slope_x_r + two_ry;
          end
        end
      end
      mer_pkg::DP_STEP_DEC: dec_nxt = dec_r + {term[45:0], 2'b00};
      mer_pkg::DP_FINISH: begin
        if (region2_r && cur_y_r[mer_pkg::Y_W-1]) begin
          active_nxt = 1'b0;
        end
      end
      mer_pkg::DP_R2_YM:   dec_nxt = $signed({4'b0, prod_r});
      mer_pkg::DP_R2_RXRY: dec_nxt = dec_r + $signed(prod_x4);
      mer_pkg::DP_R2_DONE: begin
        dec_nxt     = dec_r - $signed(prod_x4);
        region2_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  // Capture the pixel origin of a step before the update moves it
  always_comb begin
    ex_nxt       = ex_r;
    ey_nxt       = ey_r;
    last_cap_nxt = last_cap_r;
    if (cmd.capture) begin
      ex_nxt       = cur_x_r;
      ey_nxt       = cur_y_r;
      last_cap_nxt = region2_r && (cur_y_r == '0);
    end
  end

  // Result formation
  always_comb begin
    if (fill_r) begin
      xneg = 1'b1;
      yneg = !cmd.emit_sel[0];
    end else begin
      xneg = cmd.emit_sel[0];
      yneg = cmd.emit_sel[1];
    end
    out_data_nxt = out_data_r;
    out_valid_nxt = out_valid_r;
    if (cmd.emit_load) begin
      out_data_nxt.pos_x       = xneg ? ({2'b00, cx_r} - {1'b0, ex_r})
                                      : ({2'b00, cx_r} + {1'b0, ex_r});
      out_data_nxt.pos_y       = yneg ? ({2'b00, cy_r} - ey_r) : ({2'b00, cy_r} + ey_r);
      out_data_nxt.span_length = fill_r ? {ex_r[9:0], 1'b0} : 11'd1;
      out_data_nxt.out_ink     = ink_r;
      out_data_nxt.last        = last_cap_r && cmd.emit_final;
      out_valid_nxt            = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      region2_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      region2_r   <= region2_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cx_r       <= cx_nxt;
    cy_r       <= cy_nxt;
    ry_r       <= ry_nxt;
    rx_sq_r    <= rx_sq_nxt;
    ry_sq_r    <= ry_sq_nxt;
    fill_r     <= fill_nxt;
    ink_r      <= ink_nxt;
    cur_x_r    <= cur_x_nxt;
    cur_y_r    <= cur_y_nxt;
    slope_x_r  <= slope_x_nxt;
    slope_y_r  <= slope_y_nxt;
    dec_r      <= dec_nxt;
    prod_r     <= prod_nxt;
    ex_r       <= ex_nxt;
    ey_r       <= ey_nxt;
    last_cap_r <= last_cap_nxt;
    out_data_r <= out_data_nxt;
  end

  assign st.active     = active_r;
  assign st.region_two = region2_r;
  assign st.enter_r2   = !region2_r && (slope_x_r >= slope_y_r);
  assign st.fill       = fill_r;
  assign st.out_free   = out_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ rtl/core/mer_ctrl.sv @@
module mer_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_op,
  output logic                in_stall,
  input  mer_pkg::dp_status_t st,
  output mer_pkg::dp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_RY,
    ST_SQ_MIX,
    ST_INIT_DEC,
    ST_STEP_SLOPE,
    ST_STEP_DEC,
    ST_CHECK,
    ST_R2_TX,
    ST_R2_RYTX,
    ST_R2_YM,
    ST_R2_RXYM,
    ST_R2_RXRY,
    ST_R2_DONE
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] emit_left_r, emit_left_nxt;
  logic [1:0] emit_idx_r, emit_idx_nxt;
  logic       accept;

  assign in_stall = !((state_r == ST_IDLE) && (emit_left_r == 3'd0));
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.op         = mer_pkg::DP_NONE;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_op == mer_pkg::OPER_START) begin
            cmd.op    = mer_pkg::DP_START;
            state_nxt = ST_SQ_RY;
          end else if (st.active) begin
            cmd.capture = 1'b1;
            state_nxt   = ST_STEP_SLOPE;
          end
        end
      end
      ST_SQ_RY: begin
        cmd.op    = mer_pkg::DP_SQ_RY;
        state_nxt = ST_SQ_MIX;
      end
      ST_SQ_MIX: begin
        cmd.op    = mer_pkg::DP_SQ_MIX;
        state_nxt = ST_INIT_DEC;
      end
      ST_INIT_DEC: begin
        cmd.op    = mer_pkg::DP_INIT_DEC;
        state_nxt = ST_CHECK;
      end
      ST_STEP_SLOPE: begin
        cmd.op    = mer_pkg::DP_STEP_SLOPE;
        state_nxt = ST_STEP_DEC;
      end
      ST_STEP_DEC: begin
        cmd.op    = mer_pkg::DP_STEP_DEC;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (st.enter_r2) begin
          state_nxt = ST_R2_TX;
        end else begin
          cmd.op    = mer_pkg::DP_FINISH;
          state_nxt = ST_IDLE;
        end
      end
      ST_R2_TX: begin
        cmd.op    = mer_pkg::DP_R2_TX;
        state_nxt = ST_R2_RYTX;
      end
      ST_R2_RYTX: begin
        cmd.op    = mer_pkg::DP_R2_RYTX;
        state_nxt = ST_R2_YM;
      end
      ST_R2_YM: begin
        cmd.op    = mer_pkg::DP_R2_YM;
        state_nxt = ST_R2_RXYM;
      end
      ST_R2_RXYM: begin
        cmd.op    = mer_pkg::DP_R2_RXYM;
        state_nxt = ST_R2_RXRY;
      end
      ST_R2_RXRY: begin
        cmd.op    = mer_pkg::DP_R2_RXRY;
        state_nxt = ST_R2_DONE;
      end
      ST_R2_DONE: begin
        cmd.op    = mer_pkg::DP_R2_DONE;
        state_nxt = ST_CHECK;
      end
      default: state_nxt = ST_IDLE;
    endcase

    // result sequencer runs beside the update steps
    cmd.emit_load  = (emit_left_r != 3'd0) && st.out_free;
    cmd.emit_sel   = emit_idx_r;
    cmd.emit_final = (emit_left_r == 3'd1);

    emit_left_nxt = emit_left_r;
    emit_idx_nxt  = emit_idx_r;
    if (cmd.capture) begin
      emit_left_nxt = st.fill ? 3'd2 : 3'd4;
      emit_idx_nxt  = 2'd0;
    end else if (cmd.emit_load) begin
      emit_left_nxt = emit_left_r - 3'd1;
      emit_idx_nxt  = emit_idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      emit_left_r <= 3'd0;
      emit_idx_r  <= 2'd0;
    end else begin
      state_r     <= state_nxt;
      emit_left_r <= emit_left_nxt;
      emit_idx_r  <= emit_idx_nxt;
    end
  end

`ifndef SYNTH
  a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    emit_left_r <= 3'd4)
    else $error("result count out of range");

  a_step_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_op == mer_pkg::OPER_STEP && st.active)
      |=> (emit_left_r == 3'd2 || emit_left_r == 3'd4))
    else $error("step did not schedule its results");

  a_r2_from_r1: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_R2_TX) |-> !st.region_two)
    else $error("region-two setup entered from region two");

  a_final_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_load && cmd.emit_final) |=> (emit_left_r == 3'd0))
    else $error("results remain after final transfer");
`endif

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import mer_pkg::*;

  // Stop stimulus once this many meaningful transfers (starts, or steps on a
  // live ellipse) have gone in.
  localparam int ITEM_TARGET = 430;
  // Cycles with no transfer on either channel before the run is declared hung.
  localparam int QUIET_LIMIT = 3000;
  // Extra cycles after the last expected pixel, to catch stray results.
  localparam int DRAIN_CYCLES = 40;
  // Radii above this are only run for a few steps and then aborted.
  localparam int BIG_RADIUS = 60;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

  // Predicts the pixel/span stream of the midpoint ellipse walk and checks the
  // block's results against it in order.
  class ellipse_scoreboard;
    bit        running;
    bit        region_two;
    bit        fill;
    longint    cur_x;
    longint    cur_y;
    longint    slope_x;
    longint    slope_y;
    longint    dec;
    longint    ctr_x;
    longint    ctr_y;
    longint    rx_sq;
    longint    ry_sq;
    logic [7:0] ink;
    out_item_t pixel_q[$];
    int        failures;
    int        reported;

    function void setup_region_two();
      longint tx;
      longint ym;
      tx = 2 * cur_x + 1;
      ym = cur_y - 1;
      region_two = 1'b1;
      dec = ry_sq * tx * tx + 4 * rx_sq * ym * ym - 4 * rx_sq * ry_sq;
    endfunction

    function void queue_pixel(longint px, longint py, longint len, bit is_last);
      out_item_t p;
      p.pos_x       = 12'(px);
      p.pos_y       = 12'(py);
      p.span_length = 11'(len);
      p.out_ink     = ink;
      p.last        = is_last;
      pixel_q.push_back(p);
    endfunction

    function void note_transfer(in_item_t it);
      longint rx;
      longint ry;
      longint x0;
      longint y0;
      bit     done;
      if (it.operation == OPER_START) begin
        rx = longint'(it.radius_x);
        ry = longint'(it.radius_y);
        ctr_x = longint'(it.center_x);
        ctr_y = longint'(it.center_y);
        rx_sq = rx * rx;
        ry_sq = ry * ry;
        fill = it.fill_mode;
        ink = it.ink;
        cur_x = 0;
        cur_y = ry;
        slope_x = 0;
        slope_y = 2 * rx_sq * ry;
        dec = 4 * ry_sq - 4 * rx_sq * ry + rx_sq;
        region_two = 1'b0;
        running = 1'b1;
        if (slope_x >= slope_y) setup_region_two();
        return;
      end
      if (!running) return;
      x0 = cur_x;
      y0 = cur_y;
      if (!region_two) begin
        cur_x += 1;
        slope_x += 2 * ry_sq;
        if (dec < 0) begin
          dec += 4 * (slope_x + ry_sq);
        end else begin
          cur_y -= 1;
          slope_y -= 2 * rx_sq;
          dec += 4 * (slope_x - slope_y + ry_sq);
        end
        if (slope_x >= slope_y) setup_region_two();
      end else begin
        cur_y -= 1;
        slope_y -= 2 * rx_sq;
        if (dec > 0) begin
          dec += 4 * (rx_sq - slope_y);
        end else begin
          cur_x += 1;
          slope_x += 2 * ry_sq;
          dec += 4 * (slope_x - slope_y + rx_sq);
        end
      end
      done = region_two && (cur_y < 0);
      if (done) running = 1'b0;
      if (fill) begin
        queue_pixel(ctr_x - x0, ctr_y - y0, 2 * x0, 1'b0);
        queue_pixel(ctr_x - x0, ctr_y + y0, 2 * x0, done);
      end else begin
        queue_pixel(ctr_x + x0, ctr_y + y0, 1, 1'b0);
        queue_pixel(ctr_x - x0, ctr_y + y0, 1, 1'b0);
        queue_pixel(ctr_x + x0, ctr_y - y0, 1, 1'b0);
        queue_pixel(ctr_x - x0, ctr_y - y0, 1, done);
      end
    endfunction

    function string describe(out_item_t p);
      return $sformatf("x=%0d y=%0d len=%0d ink=%02h last=%0b",
                       p.pos_x, p.pos_y, p.span_length, p.out_ink, p.last);
    endfunction

    function void flag(string msg);
      failures++;
      if (reported < 10) begin
        reported++;
        $display("ERROR @%0t: %s", $time, msg);
      end
    endfunction

    function void check_pixel(out_item_t got);
      out_item_t want;
      if (pixel_q.size() == 0) begin
        flag({"unexpected result ", describe(got)});
        return;
      end
      want = pixel_q.pop_front();
      if (got.pos_x !== want.pos_x || got.pos_y !== want.pos_y ||
          got.span_length !== want.span_length || got.out_ink !== want.out_ink ||
          got.last !== want.last)
        flag({"mismatch: want ", describe(want), " got ", describe(got)});
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  ellipse_scoreboard sb;
  int items_sent = 0;
  int burst_left = 0;
  int quiet_cycles = 0;

  midpoint_ellipse_rasterizer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Sample both channels at the rising edge: feed accepted inputs to the
  // predictor, check accepted results, and track how long nothing has moved.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_transfer(in_data);
      if (out_valid && !out_stall) sb.check_pixel(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Watchdog: end the run if no transfer happens for too long.
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  // Receiver back-pressure: switch between stall patterns at random intervals,
  // including stretches with no stall at all.
  initial begin
    stall_mode_t mode;
    int          span;
    int          k;
    forever begin
      mode = stall_mode_t'($urandom_range(0, 3));
      span = $urandom_range(8, 64);
      for (k = 0; k < span; k++) begin
        @(negedge clk);
        case (mode)
          STALL_NONE:   out_stall <= 1'b0;
          STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
          default:      out_stall <= k[0];
        endcase
      end
    end
  end

  // Random filler for every field; callers override what matters.
  function automatic in_item_t random_item(logic op);
    logic [49:0] raw;
    in_item_t    it;
    raw = 50'({$urandom, $urandom});
    it = raw;
    it.operation = op;
    return it;
  endfunction

  function automatic in_item_t start_item(int cx, int cy, int rx, int ry,
                                          bit fill_on, int color);
    in_item_t it;
    it = random_item(OPER_START);
    it.center_x  = 10'(cx);
    it.center_y  = 10'(cy);
    it.radius_x  = 10'(rx);
    it.radius_y  = 10'(ry);
    it.fill_mode = fill_on;
    it.ink       = 8'(color);
    return it;
  endfunction

  // Mostly small radii so ellipses finish; some medium, a few full range.
  function automatic logic [9:0] pick_radius();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return 10'($urandom_range(0, 12));
    if (r < 9) return 10'($urandom_range(13, BIG_RADIUS));
    return 10'($urandom_range(0, 1023));
  endfunction

  // Drive one transfer. Called at a falling edge; returns at the falling edge
  // after acceptance with valid still high, so back-to-back items in a burst never drop it.
  task automatic send_item(in_item_t it);
    int gap;
    if (it.operation == OPER_START || sb.running) items_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    burst_left--;
  endtask

  // Advance the current ellipse until it ends or the step budget runs out.
  task automatic run_steps(int budget);
    int n;
    n = 0;
    while (sb.running && n < budget) begin
      send_item(random_item(OPER_STEP));
      n++;
    end
  endtask

  initial begin
    in_item_t it;
    int       rx;
    int       ry;
    int       budget;
    sb = new();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: a step with nothing running is ignored.
    send_item(random_item(OPER_STEP));
    // Both radii zero at the origin: one step and done.
    send_item(start_item(0, 0, 0, 0, 1'b0, 8'h00));
    run_steps(4);
    // Largest center and radii, filled; abort after a few steps.
    send_item(start_item(1023, 1023, 1023, 1023, 1'b1, 8'hFF));
    run_steps(3);
    // Largest radii at the origin: coordinates go negative.
    send_item(start_item(0, 0, 1023, 1023, 1'b0, 8'hAA));
    run_steps(3);
    // Zero horizontal radius: region two from the start, zero-length spans.
    send_item(start_item(512, 300, 0, 3, 1'b1, 8'h55));
    run_steps(10);
    // Zero vertical radius: all mirrored pixels coincide in pairs.
    send_item(start_item(5, 1020, 3, 0, 1'b0, 8'h0F));
    run_steps(4);
    // Small circle run to completion, then a stray step.
    send_item(start_item(1000, 7, 2, 2, 1'b0, 8'hF0));
    run_steps(10);
    send_item(random_item(OPER_STEP));

    // Random: mostly complete ellipses, some aborted, some noise.
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 99) < 85) begin
        rx = int'(pick_radius());
        ry = int'(pick_radius());
        it = random_item(OPER_START);
        it.radius_x = 10'(rx);
        it.radius_y = 10'(ry);
        send_item(it);
        if (rx > BIG_RADIUS || ry > BIG_RADIUS)
          budget = $urandom_range(1, 40);
        else if ($urandom_range(0, 7) == 0)
          budget = $urandom_range(0, 6);
        else
          budget = 1 << 20;
        run_steps(budget);
        if (!sb.running && $urandom_range(0, 3) == 0)
          send_item(random_item(OPER_STEP));
      end else begin
        send_item(random_item(1'($urandom_range(0, 1))));
      end
    end
    in_valid <= 1'b0;

    // Drain: wait for every predicted pixel, then linger for strays.
    while (sb.pixel_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.failures == 0 && sb.pixel_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ midpoint_ellipse_rasterizer.f @@
rtl/core/mer_pkg.sv
rtl/core/mer_dp.sv
rtl/core/mer_ctrl.sv
rtl/core/midpoint_ellipse_rasterizer.sv
sim/tb_top.sv
